[rtl/core/cylinder_sdf_band_evaluator_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the cylinder distance core
// Shared helpers for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef CYLINDER_SDF_BAND_EVALUATOR_CORE_DEFINES_SVH
`define CYLINDER_SDF_BAND_EVALUATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CYLSDF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cylinder core check failed");

// The consequent must hold in the cycle after the antecedent.
`define CYLSDF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cylinder core check failed");

`endif

[rtl/core/cylsdf_pkg.sv]
// ---------------------------------------------------------------------------
// cylsdf_pkg
// Types, widths and register indices for the cylinder distance core.
// ---------------------------------------------------------------------------
package cylsdf_pkg;

    localparam int COORD_W   = 32;
    localparam int LEN_W     = 31;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Internal widths, sized from the coordinate range.
    localparam int DIFF_W = COORD_W + 1;      // point or top minus bottom
    localparam int SQ_W   = 2 * COORD_W;      // one square, below 2^64
    localparam int PROD_W = 2 * DIFF_W;       // signed cross product
    localparam int NN_W   = SQ_W + 2;         // sum of three squares
    localparam int DOT_W  = NN_W + 1;         // signed dot product
    localparam int H_W    = NN_W / 2;         // axis length
    localparam int AQ_W   = H_W + 2;          // axial coordinate magnitude
    localparam int AA_W   = 2 * AQ_W;         // its square
    localparam int CAND_W = AQ_W + 3;         // signed distance candidates

    localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_Z = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP_X    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP_Y    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TOP_Z    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RADIUS   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND     = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] distance;
        logic                      in_band;
        logic                      degenerate;
    } result_t;

endpackage

[rtl/core/cylsdf_sqrt_pipe.sv]
// ---------------------------------------------------------------------------
// cylsdf_sqrt_pipe
// Pipelined integer square root, one result bit per stage, with side data.
// ---------------------------------------------------------------------------
module cylsdf_sqrt_pipe #(
    parameter int RAD_W  = cylsdf_pkg::NN_W,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  vld_in,
    input  logic [RAD_W-1:0]      rad_in,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  vld_out,
    output logic [RAD_W/2-1:0]    root_out,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              vld_reg  [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_stage
        logic              s_vld;
        logic [RAD_W-1:0]  s_rad;
        logic [ROOT_W-1:0] s_root;
        logic [REM_W-1:0]  s_rem;
        logic [SIDE_W-1:0] s_side;
        logic [REM_W-1:0]  shifted;
        logic [REM_W:0]    diff;

        if (g == 0)
        begin : g_first
            assign s_vld  = vld_in;
            assign s_rad  = rad_in;
            assign s_root = '0;
            assign s_rem  = '0;
            assign s_side = side_in;
        end
        else
        begin : g_next
            assign s_vld  = vld_reg[g-1];
            assign s_rad  = rad_reg[g-1];
            assign s_root = root_reg[g-1];
            assign s_rem  = rem_reg[g-1];
            assign s_side = side_reg[g-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign shifted = {s_rem[REM_W-3:0], s_rad[RAD_W-1 -: 2]};
        assign diff    = {1'b0, shifted} - {1'b0, s_root, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= s_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g]  <= s_rad << 2;
                side_reg[g] <= s_side;
                if (!diff[REM_W])
                begin
                    rem_reg[g]  <= diff[REM_W-1:0];
                    root_reg[g] <= {s_root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g]  <= shifted;
                    root_reg[g] <= {s_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign vld_out  = vld_reg[ROOT_W-1];
    assign root_out = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

[rtl/core/cylsdf_div_pipe.sv]
// ---------------------------------------------------------------------------
// cylsdf_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ---------------------------------------------------------------------------
module cylsdf_div_pipe #(
    parameter int DVD_W  = cylsdf_pkg::NN_W,
    parameter int DVS_W  = cylsdf_pkg::H_W,
    parameter int Q_W    = cylsdf_pkg::AQ_W,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  logic [DVD_W-1:0]  dvd_in,
    input  logic [DVS_W-1:0]  dvs_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              vld_out,
    output logic [Q_W-1:0]    quo_out,
    output logic [SIDE_W-1:0] side_out
);

    // The quotient is known to fit Q_W bits, so the upper dividend bits
    // already sit below the divisor and can seed the remainder.
    logic              vld_reg  [Q_W];
    logic [DVS_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    lo_reg   [Q_W];
    logic [Q_W-1:0]    quo_reg  [Q_W];
    logic [DVS_W-1:0]  dvs_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar g = 0; g < Q_W; g++)
    begin : g_stage
        logic              s_vld;
        logic [DVS_W-1:0]  s_rem;
        logic [Q_W-1:0]    s_lo;
        logic [Q_W-1:0]    s_quo;
        logic [DVS_W-1:0]  s_dvs;
        logic [SIDE_W-1:0] s_side;
        logic [DVS_W:0]    trial;
        logic [DVS_W:0]    diff;
        logic              fits;

        if (g == 0)
        begin : g_first
            assign s_vld  = vld_in;
            assign s_rem  = DVS_W'(dvd_in[DVD_W-1:Q_W]);
            assign s_lo   = dvd_in[Q_W-1:0];
            assign s_quo  = '0;
            assign s_dvs  = dvs_in;
            assign s_side = side_in;
        end
        else
        begin : g_next
            assign s_vld  = vld_reg[g-1];
            assign s_rem  = rem_reg[g-1];
            assign s_lo   = lo_reg[g-1];
            assign s_quo  = quo_reg[g-1];
            assign s_dvs  = dvs_reg[g-1];
            assign s_side = side_reg[g-1];
        end

        assign trial = {s_rem, s_lo[Q_W-1]};
        assign diff  = trial - {1'b0, s_dvs};
        assign fits  = trial >= {1'b0, s_dvs};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= s_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lo_reg[g]   <= s_lo << 1;
                dvs_reg[g]  <= s_dvs;
                side_reg[g] <= s_side;
                quo_reg[g]  <= {s_quo[Q_W-2:0], fits};
                rem_reg[g]  <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            end
        end
    end

    assign vld_out  = vld_reg[Q_W-1];
    assign quo_out  = quo_reg[Q_W-1];
    assign side_out = side_reg[Q_W-1];

endmodule

[rtl/core/cylinder_sdf_band_evaluator_core.sv]
// ---------------------------------------------------------------------------
// cylinder_sdf_band_evaluator_core
// Signed distance from a query point to a capped cylinder, with band flag.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Payload                Request
//  pt        pt_valid / pt_stall    cylsdf_pkg::point_t    one query point
//  res       res_valid / res_stall  cylsdf_pkg::result_t   one distance result
//  cfg       cfg_we                 cfg_addr / cfg_wdata   one register write
//
// A request may enter on every cycle while pt_stall is low.  The pipeline
// depth comes mostly from the two bit-per-stage square root units
// (33 stages each) and the bit-per-stage divider (35 stages).
// Reset clears all valid bits and loads the register defaults.  A stalled
// result is held in the output register and one further result is caught
// in a skid register; only when that is occupied does pt_stall rise and
// the whole pipeline hold.
//
// Datapath: the axis d = top - bottom and offset v = point - bottom are
// formed, squared and cross multiplied, and summed into |d|^2, |v|^2 and
// v.d.  The axis length h is the root of |d|^2, the axial coordinate is
// |v.d| / h with its sign restored, and the radial distance is the root
// of |v|^2 - alpha^2 (clamped at zero).  The largest of the two cap
// distances and the radial one is saturated to 32 bits.  A zero axis
// forces a zero distance with the degenerate flag.
// ---------------------------------------------------------------------------
`include "cylinder_sdf_band_evaluator_core_defines.svh"

module cylinder_sdf_band_evaluator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  pt_valid,
    output logic                                  pt_stall,
    input  cylsdf_pkg::point_t                    pt_data,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output cylsdf_pkg::result_t                   res_data,
    input  logic                                  cfg_we,
    input  logic [cylsdf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cylsdf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int COORD_W = cylsdf_pkg::COORD_W;
    localparam int LEN_W   = cylsdf_pkg::LEN_W;
    localparam int DIFF_W  = cylsdf_pkg::DIFF_W;
    localparam int SQ_W    = cylsdf_pkg::SQ_W;
    localparam int PROD_W  = cylsdf_pkg::PROD_W;
    localparam int NN_W    = cylsdf_pkg::NN_W;
    localparam int DOT_W   = cylsdf_pkg::DOT_W;
    localparam int H_W     = cylsdf_pkg::H_W;
    localparam int AQ_W    = cylsdf_pkg::AQ_W;
    localparam int AA_W    = cylsdf_pkg::AA_W;
    localparam int CAND_W  = cylsdf_pkg::CAND_W;

    localparam int SQ1_SIDE_W = 2 + 2 * NN_W;
    localparam int DIV_SIDE_W = 2 + NN_W + H_W;
    localparam int SQ2_SIDE_W = 2 + AQ_W + H_W;

    // -----------------------------------------------------------------
    // Configuration registers.
    // -----------------------------------------------------------------
    logic signed [COORD_W-1:0] bot_reg [3];
    logic signed [COORD_W-1:0] top_reg [3];
    logic        [LEN_W-1:0]   radius_reg;
    logic        [LEN_W-1:0]   band_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bot_reg[0] <= '0;
            bot_reg[1] <= '0;
            bot_reg[2] <= '0;
            top_reg[0] <= '0;
            top_reg[1] <= '0;
            top_reg[2] <= 32'sd65536;
            radius_reg <= 31'd65536;
            band_reg   <= 31'd196608;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cylsdf_pkg::REG_BOTTOM_X: bot_reg[0] <= cfg_wdata;
                cylsdf_pkg::REG_BOTTOM_Y: bot_reg[1] <= cfg_wdata;
                cylsdf_pkg::REG_BOTTOM_Z: bot_reg[2] <= cfg_wdata;
                cylsdf_pkg::REG_TOP_X:    top_reg[0] <= cfg_wdata;
                cylsdf_pkg::REG_TOP_Y:    top_reg[1] <= cfg_wdata;
                cylsdf_pkg::REG_TOP_Z:    top_reg[2] <= cfg_wdata;
                cylsdf_pkg::REG_RADIUS:   radius_reg <= cfg_wdata[LEN_W-1:0];
                cylsdf_pkg::REG_BAND:     band_reg   <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------
    // Pipeline advance.  Everything moves together unless the skid
    // register is holding a result.
    // -----------------------------------------------------------------
    logic en;
    logic skid_vld_reg;

    assign en       = !skid_vld_reg;
    assign pt_stall = !en;

    // Stage 1: axis and offset vectors.
    logic                     s1_vld_reg;
    logic signed [DIFF_W-1:0] d_reg [3];
    logic signed [DIFF_W-1:0] v_reg [3];
    logic signed [COORD_W-1:0] pt_coord [3];

    assign pt_coord[0] = pt_data.point_x;
    assign pt_coord[1] = pt_data.point_y;
    assign pt_coord[2] = pt_data.point_z;

    // Stage 2: squares and cross products.
    logic                     s2_vld_reg;
    logic        [SQ_W-1:0]   dd_reg [3];
    logic        [SQ_W-1:0]   vv_reg [3];
    logic signed [PROD_W-1:0] dv_reg [3];

    // Stage 3: the three sums.
    logic                    s3_vld_reg;
    logic        [NN_W-1:0]  nn_reg;
    logic        [NN_W-1:0]  vsum_reg;
    logic signed [DOT_W-1:0] dot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= pt_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]  <= DIFF_W'(top_reg[i]) - DIFF_W'(bot_reg[i]);
                v_reg[i]  <= DIFF_W'(pt_coord[i]) - DIFF_W'(bot_reg[i]);
                dd_reg[i] <= SQ_W'(PROD_W'(d_reg[i] * d_reg[i]));
                vv_reg[i] <= SQ_W'(PROD_W'(v_reg[i] * v_reg[i]));
                dv_reg[i] <= PROD_W'(d_reg[i] * v_reg[i]);
            end
            nn_reg   <= NN_W'(dd_reg[0]) + NN_W'(dd_reg[1]) + NN_W'(dd_reg[2]);
            vsum_reg <= NN_W'(vv_reg[0]) + NN_W'(vv_reg[1]) + NN_W'(vv_reg[2]);
            dot_reg  <= DOT_W'(dv_reg[0]) + DOT_W'(dv_reg[1]) + DOT_W'(dv_reg[2]);
        end
    end

    // -----------------------------------------------------------------
    // Axis length.  The magnitude and sign of the dot product, |v|^2 and
    // the zero-axis flag ride alongside.
    // -----------------------------------------------------------------
    logic [NN_W-1:0]      dot_abs;
    logic                 dot_neg;
    logic                 axis_zero;
    logic [SQ1_SIDE_W-1:0] sq1_side_in;
    logic [SQ1_SIDE_W-1:0] sq1_side_out;
    logic                 sq1_vld;
    logic [H_W-1:0]       h_root;

    assign dot_neg     = dot_reg[DOT_W-1];
    assign dot_abs     = dot_neg ? NN_W'(-dot_reg) : dot_reg[NN_W-1:0];
    assign axis_zero   = (nn_reg == '0);
    assign sq1_side_in = {axis_zero, dot_neg, vsum_reg, dot_abs};

    cylsdf_sqrt_pipe #(
        .RAD_W  (NN_W),
        .SIDE_W (SQ1_SIDE_W)
    ) u_sqrt_len (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (s3_vld_reg),
        .rad_in   (nn_reg),
        .side_in  (sq1_side_in),
        .vld_out  (sq1_vld),
        .root_out (h_root),
        .side_out (sq1_side_out)
    );

    // -----------------------------------------------------------------
    // Axial coordinate magnitude |v.d| / h.
    // -----------------------------------------------------------------
    logic [DIV_SIDE_W-1:0] div_side_in;
    logic [DIV_SIDE_W-1:0] div_side_out;
    logic                  div_vld;
    logic [AQ_W-1:0]       aq;

    assign div_side_in = {sq1_side_out[SQ1_SIDE_W-1 -: 2 + NN_W], h_root};

    cylsdf_div_pipe #(
        .DVD_W  (NN_W),
        .DVS_W  (H_W),
        .Q_W    (AQ_W),
        .SIDE_W (DIV_SIDE_W)
    ) u_div_alpha (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (sq1_vld),
        .dvd_in   (sq1_side_out[NN_W-1:0]),
        .dvs_in   (h_root),
        .side_in  (div_side_in),
        .vld_out  (div_vld),
        .quo_out  (aq),
        .side_out (div_side_out)
    );

    // Stage A: alpha squared.  Stage B: radial radicand, clamped at zero.
    logic                 sa_vld_reg;
    logic [AA_W-1:0]      aa_reg;
    logic [NN_W-1:0]      sa_vv_reg;
    logic [H_W-1:0]       sa_h_reg;
    logic [AQ_W-1:0]      sa_aq_reg;
    logic                 sa_neg_reg;
    logic                 sa_zero_reg;

    logic                 sb_vld_reg;
    logic [NN_W-1:0]      rad_reg;
    logic [SQ2_SIDE_W-1:0] sb_side_reg;
    logic [AA_W-1:0]      vv_ext;
    logic [AA_W-1:0]      rad_diff;

    assign vv_ext   = AA_W'(sa_vv_reg);
    assign rad_diff = vv_ext - aa_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_vld_reg <= 1'b0;
            sb_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sa_vld_reg <= div_vld;
            sb_vld_reg <= sa_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aa_reg      <= aq * aq;
            sa_vv_reg   <= div_side_out[H_W +: NN_W];
            sa_h_reg    <= div_side_out[H_W-1:0];
            sa_aq_reg   <= aq;
            sa_neg_reg  <= div_side_out[DIV_SIDE_W-2];
            sa_zero_reg <= div_side_out[DIV_SIDE_W-1];
            rad_reg     <= (vv_ext > aa_reg) ? rad_diff[NN_W-1:0] : '0;
            sb_side_reg <= {sa_zero_reg, sa_neg_reg, sa_aq_reg, sa_h_reg};
        end
    end

    // -----------------------------------------------------------------
    // Perpendicular distance.
    // -----------------------------------------------------------------
    logic [SQ2_SIDE_W-1:0] sq2_side_out;
    logic                  sq2_vld;
    logic [H_W-1:0]        perp;

    cylsdf_sqrt_pipe #(
        .RAD_W  (NN_W),
        .SIDE_W (SQ2_SIDE_W)
    ) u_sqrt_perp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (sb_vld_reg),
        .rad_in   (rad_reg),
        .side_in  (sb_side_reg),
        .vld_out  (sq2_vld),
        .root_out (perp),
        .side_out (sq2_side_out)
    );

    // Stage C: the three candidates.  Stage D: their maximum.
    logic signed [CAND_W-1:0] alpha;
    logic                     sc_vld_reg;
    logic signed [CAND_W-1:0] cand_reg [3];
    logic                     sc_zero_reg;
    logic                     sd_vld_reg;
    logic signed [CAND_W-1:0] dist_reg;
    logic                     sd_zero_reg;
    logic signed [CAND_W-1:0] max01;

    assign alpha = sq2_side_out[SQ2_SIDE_W-2] ?
                   -CAND_W'(sq2_side_out[H_W +: AQ_W]) :
                   CAND_W'(sq2_side_out[H_W +: AQ_W]);
    assign max01 = (cand_reg[1] > cand_reg[0]) ? cand_reg[1] : cand_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_vld_reg <= 1'b0;
            sd_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sc_vld_reg <= sq2_vld;
            sd_vld_reg <= sc_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cand_reg[0] <= -alpha;
            cand_reg[1] <= alpha - CAND_W'(sq2_side_out[H_W-1:0]);
            cand_reg[2] <= CAND_W'(perp) - CAND_W'(radius_reg);
            sc_zero_reg <= sq2_side_out[SQ2_SIDE_W-1];
            dist_reg    <= (cand_reg[2] > max01) ? cand_reg[2] : max01;
            sd_zero_reg <= sc_zero_reg;
        end
    end

    // -----------------------------------------------------------------
    // Saturation, band test and the zero-axis override.
    // -----------------------------------------------------------------
    localparam int SAT_HI_W = CAND_W - COORD_W + 1;

    logic [SAT_HI_W-1:0]       dist_hi;
    logic signed [COORD_W-1:0] dist_sat;
    logic        [COORD_W-1:0] dist_mag;
    cylsdf_pkg::result_t       fin_data;

    assign dist_hi = dist_reg[CAND_W-1 -: SAT_HI_W];

    always_comb
    begin
        if (dist_hi == '0 || dist_hi == '1)
        begin
            dist_sat = dist_reg[COORD_W-1:0];
        end
        else if (dist_reg[CAND_W-1])
        begin
            dist_sat = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            dist_sat = {1'b0, {(COORD_W-1){1'b1}}};
        end
        dist_mag = dist_sat[COORD_W-1] ? COORD_W'(-dist_sat) : dist_sat;

        if (sd_zero_reg)
        begin
            fin_data.distance   = '0;
            fin_data.in_band    = 1'b1;
            fin_data.degenerate = 1'b1;
        end
        else
        begin
            fin_data.distance   = dist_sat;
            fin_data.in_band    = dist_mag <= COORD_W'(band_reg);
            fin_data.degenerate = 1'b0;
        end
    end

    // -----------------------------------------------------------------
    // Output register with one skid entry behind it.
    // -----------------------------------------------------------------
    logic                res_vld_reg;
    cylsdf_pkg::result_t res_data_reg;
    cylsdf_pkg::result_t skid_data_reg;
    logic                take;

    assign take      = res_vld_reg && !res_stall;
    assign res_valid = res_vld_reg;
    assign res_data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (take)
            begin
                res_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end
        else if (!res_vld_reg || take)
        begin
            res_vld_reg <= sd_vld_reg;
        end
        else if (sd_vld_reg)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
            begin
                res_data_reg <= skid_data_reg;
            end
        end
        else if (!res_vld_reg || take)
        begin
            res_data_reg <= fin_data;
        end
        else if (sd_vld_reg)
        begin
            skid_data_reg <= fin_data;
        end
    end

    // -----------------------------------------------------------------
    // Checks.
    // -----------------------------------------------------------------
    `CYLSDF_ASSERT_NOW(a_degen_zero, res_valid && res_data.degenerate,
        res_data.distance == '0 && res_data.in_band)
    `CYLSDF_ASSERT_NOW(a_skid_behind_out, skid_vld_reg, res_vld_reg)
    `CYLSDF_ASSERT_NEXT(a_skid_holds, skid_vld_reg && res_stall, skid_vld_reg)

endmodule

[tb/cylsdf_checker.sv]
// ---------------------------------------------------------------------------
// cylsdf_checker
// Follows the register writes, predicts the cylinder distance result for
// every accepted query point and compares each accepted result with it.
// ---------------------------------------------------------------------------
module cylsdf_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pt_valid,
    input  logic                              pt_stall,
    input  cylsdf_pkg::point_t                pt_data,
    input  logic                              res_valid,
    input  logic                              res_stall,
    input  cylsdf_pkg::result_t               res_data,
    input  logic                              cfg_we,
    input  logic [cylsdf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cylsdf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                mismatches,
    output int                                outstanding
);

    logic [31:0]         cyl_reg [8];
    cylsdf_pkg::result_t expected_results [$];

    // Integer square root, rounded down.
    function automatic logic [63:0] floor_sqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = 128'(r | (64'd1 << b));
            if (t * t <= n)
                r = t[63:0];
        end
        return r;
    endfunction

    function automatic cylsdf_pkg::result_t cylinder_distance(cylsdf_pkg::point_t p);
        cylsdf_pkg::result_t r;
        longint             dd, vd;
        logic signed [127:0] ds, vs, dot, alpha, dval;
        logic [127:0]       nn, vv, dm, vm, sabs, aq, aa, h, perp;
        longint             dl;
        logic [31:0]        pc [3];
        pc[0] = p.point_x;
        pc[1] = p.point_y;
        pc[2] = p.point_z;
        nn  = '0;
        vv  = '0;
        dot = '0;
        for (int i = 0; i < 3; i++) begin
            dd  = longint'($signed(cyl_reg[3 + i])) - longint'($signed(cyl_reg[i]));
            vd  = longint'($signed(pc[i])) - longint'($signed(cyl_reg[i]));
            ds  = dd;
            vs  = vd;
            dm  = (dd < 0) ? 128'(-dd) : 128'(dd);
            vm  = (vd < 0) ? 128'(-vd) : 128'(vd);
            nn  = nn + dm * dm;
            vv  = vv + vm * vm;
            dot = dot + ds * vs;
        end
        if (nn == 0) begin
            r.distance   = '0;
            r.in_band    = 1'b1;
            r.degenerate = 1'b1;
            return r;
        end
        h     = 128'(floor_sqrt(nn));
        sabs  = (dot < 0) ? -dot : dot;
        aq    = sabs / h;
        alpha = (dot < 0) ? -$signed(aq) : $signed(aq);
        aa    = aq * aq;
        perp  = (vv <= aa) ? '0 : 128'(floor_sqrt(vv - aa));
        dval  = -alpha;
        if (alpha - $signed(h) > dval)
            dval = alpha - $signed(h);
        if ($signed(perp) - $signed(128'(cyl_reg[cylsdf_pkg::REG_RADIUS][30:0])) > dval)
            dval = $signed(perp) - $signed(128'(cyl_reg[cylsdf_pkg::REG_RADIUS][30:0]));
        if (dval > 128'sh7FFFFFFF)
            dval = 128'sh7FFFFFFF;
        if (dval < -128'sh80000000)
            dval = -128'sh80000000;
        dl = longint'(dval);
        r.distance   = dval[31:0];
        r.in_band    = ((dl < 0) ? -dl : dl)
                       <= longint'(cyl_reg[cylsdf_pkg::REG_BAND][30:0]);
        r.degenerate = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyl_reg[0] <= '0;
            cyl_reg[1] <= '0;
            cyl_reg[2] <= '0;
            cyl_reg[3] <= '0;
            cyl_reg[4] <= '0;
            cyl_reg[5] <= 32'd65536;
            cyl_reg[6] <= 32'd65536;
            cyl_reg[7] <= 32'd196608;
            mismatches  <= 0;
            outstanding <= 0;
            expected_results.delete();
        end
        else
        begin
            cylsdf_pkg::result_t want;
            if (cfg_we)
                cyl_reg[cfg_addr] <= (cfg_addr >= cylsdf_pkg::REG_RADIUS)
                                     ? {1'b0, cfg_wdata[30:0]} : cfg_wdata;
            if (pt_valid && !pt_stall)
                expected_results.push_back(cylinder_distance(pt_data));
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: %p", res_data);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.distance !== res_data.distance || want.in_band !== res_data.in_band
                        || want.degenerate !== res_data.degenerate)
                    begin
                        if (mismatches < 10)
                            $display("result mismatch: expected %p, got %p", want, res_data);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Drives query points and register settings into the cylinder distance
// core with random idling on both sides and gives the final verdict.
// ---------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 285;
    localparam int HOLD_CYCLES = 400;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  pt_valid = 1'b0;
    logic                                  pt_stall;
    cylsdf_pkg::point_t                    pt_data = '0;
    logic                                  res_valid;
    logic                                  res_stall = 1'b0;
    cylsdf_pkg::result_t                   res_data;
    logic                                  cfg_we = 1'b0;
    logic [cylsdf_pkg::CFG_ADDR_W-1:0]     cfg_addr = '0;
    logic [cylsdf_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int results_taken = 0;
    int idle_cycles = 0;
    // When clear, the side concerned runs flat out for a while.
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    cylinder_sdf_band_evaluator_core dut (
        .clk(clk), .rst_n(rst_n),
        .pt_valid(pt_valid), .pt_stall(pt_stall), .pt_data(pt_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    cylsdf_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .pt_valid(pt_valid), .pt_stall(pt_stall), .pt_data(pt_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    // The watchdog is cleared by any accepted request or result, so that a
    // hung handshake ends the run rather than the simulation hanging.
    always @(posedge clk)
    begin
        if ((pt_valid && !pt_stall) || (res_valid && !res_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[cylinder_sdf_band_evaluator_core] ERROR");
            $finish;
        end
    end

    // Receiver: a random hold before each result, and once a long hold so
    // that the result skid fills, the pipeline stops and pt_stall rises
    // while the sender keeps offering requests.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            if (results_taken % 120 == 0)
                receiver_idles = $urandom_range(0, 2) != 0;
            n = receiver_idles ? $urandom_range(0, 18) : 0;
            if (results_taken == 300)
                n = HOLD_CYCLES;
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(negedge clk);
            while (!res_valid)
                @(negedge clk);
            @(posedge clk);
            results_taken++;
        end
    end

    // Offers one request, holding it until accepted. Returns straight after
    // the accepting edge, with pt_valid still high.
    task automatic send_point(cylsdf_pkg::point_t p);
        int gap;
        gap = sender_idles ? $urandom_range(0, 18) : 0;
        if (gap > 0)
        begin
            pt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_valid <= 1'b1;
        pt_data  <= p;
        @(negedge clk);
        while (pt_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic write_reg(logic [cylsdf_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // Registers change only once the core has drained.
    task automatic wait_drained();
        pt_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_cylinder(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                  logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                  logic [31:0] radius, logic [31:0] band);
        wait_drained();
        write_reg(cylsdf_pkg::REG_BOTTOM_X, bx);
        write_reg(cylsdf_pkg::REG_BOTTOM_Y, by);
        write_reg(cylsdf_pkg::REG_BOTTOM_Z, bz);
        write_reg(cylsdf_pkg::REG_TOP_X, tx);
        write_reg(cylsdf_pkg::REG_TOP_Y, ty);
        write_reg(cylsdf_pkg::REG_TOP_Z, tz);
        write_reg(cylsdf_pkg::REG_RADIUS, radius);
        write_reg(cylsdf_pkg::REG_BAND, band);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] near_value(int scale);
        return $urandom_range(0, 2 * scale) - scale;
    endfunction

    // Mostly points close to the cylinder, where cap and radial distances
    // compete; the rest cover the full coordinate range.
    function automatic cylsdf_pkg::point_t random_point();
        cylsdf_pkg::point_t p;
        if ($urandom_range(0, 3) == 0)
        begin
            p.point_x = $urandom();
            p.point_y = $urandom();
            p.point_z = $urandom();
        end
        else
        begin
            p.point_x = near_value(1 << 19);
            p.point_y = near_value(1 << 19);
            p.point_z = near_value(1 << 19);
        end
        return p;
    endfunction

    task automatic send_random_points();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
                sender_idles = $urandom_range(0, 2) != 0;
            send_point(random_point());
        end
    endtask

    initial
    begin
        cylsdf_pkg::point_t p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests against the reset cylinder: unit radius, axis
        // along z from the origin to one.
        send_point('{32'sd0, 32'sd0, 32'sd0});
        send_point('{32'sd0, 32'sd0, 32'sd65536});
        send_point('{32'sd0, 32'sd0, 32'sd32768});
        send_point('{32'sd65536, 32'sd0, 32'sd32768});
        send_point('{32'sd0, 32'sd0, -32'sd65536});
        send_point('{32'sd0, 32'sd0, 32'sd196608});
        send_point('{32'sd262144, 32'sd0, 32'sd32768});
        send_point('{32'sd131072, 32'sd131072, 32'sd131072});
        send_point('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
        send_point('{32'h80000000, 32'h80000000, 32'h80000000});
        send_point('{32'h80000000, 32'h7FFFFFFF, 32'h80000000});
        send_point('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
        send_point('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
        send_point('{32'h55555555, 32'hAAAAAAAA, 32'h55555555});
        send_point('{32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA});
        send_random_points();

        // Axis from the most negative corner to the most positive, widest
        // radius and a zero band.
        write_cylinder(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
        send_point('{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
        send_point('{32'h0, 32'h0, 32'h0});
        send_point('{32'h80000000, 32'h80000000, 32'h80000000});
        send_random_points();

        // Reversed extreme axis, zero radius and the widest band.
        write_cylinder(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h7FFFFFFF);
        send_point('{32'h0, 32'h0, 32'h0});
        send_point('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000});
        send_random_points();

        // Top equal to bottom: a zero-length axis.
        p = random_point();
        write_cylinder(p.point_x, p.point_y, p.point_z, p.point_x, p.point_y, p.point_z,
                       $urandom(), $urandom());
        send_point(p);
        send_random_points();

        // A moderate, randomly placed cylinder near the origin.
        write_cylinder(near_value(1 << 20), near_value(1 << 20), near_value(1 << 20),
                       near_value(1 << 20), near_value(1 << 20), near_value(1 << 20),
                       $urandom_range(0, 1 << 19), $urandom_range(0, 1 << 20));
        send_random_points();

        // Every register bit pattern at random.
        write_cylinder($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
        send_random_points();

        wait_drained();
        repeat (120) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[cylinder_sdf_band_evaluator_core] OK");
        else
            $display("[cylinder_sdf_band_evaluator_core] ERROR");
        $finish;
    end

endmodule
